// File: rtl/lld_pkg.sv
// Package for the least-loaded dispatcher: operation and status codes, reset
// values and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package lld_pkg;

    localparam int MAX_WORKERS_DEF = 16;

    localparam int COOKS_W = 7;
    localparam logic [COOKS_W-1:0] COOKS_RESET = 7'd5;

    localparam int LOAD_W  = 8;
    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 4;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DONE     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EXIT     = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INACTIVE = 2'd2;

    typedef struct packed {
        logic load_item;
        logic decode;
        logic scan_start;
        logic exit_start;
        logic step;
        logic disp_apply;
        logic done_rd;
        logic done_wr;
        logic exit_apply;
        logic load_out;
    } lld_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              idx_active;
        logic              walk_done;
        logic              out_free;
    } lld_stat_t;

endpackage

// File: rtl/lld_ctrl.sv
// Controller for the least-loaded dispatcher: sequences decode, table scan,
// load update, table compaction and result hand-off. Depends on lld_pkg.
`timescale 1ns / 1ps

module lld_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lld_pkg::lld_stat_t stat,
    output lld_pkg::lld_cmd_t  cmd
);
    import lld_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DISP   = 3'd3;
    localparam logic [2:0] S_DRD    = 3'd4;
    localparam logic [2:0] S_DWR    = 3'd5;
    localparam logic [2:0] S_EXIT   = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_item = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (stat.func == FUNC_DISPATCH)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (stat.func == FUNC_DONE && stat.idx_active)
                begin
                    state_next = S_DRD;
                end
                else if (stat.func == FUNC_EXIT && stat.idx_active)
                begin
                    cmd.exit_start = 1'b1;
                    state_next     = S_EXIT;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.disp_apply = 1'b1;
                state_next     = S_RESULT;
            end
            S_DRD:
            begin
                cmd.done_rd = 1'b1;
                state_next  = S_DWR;
            end
            S_DWR:
            begin
                cmd.done_wr = 1'b1;
                state_next  = S_RESULT;
            end
            S_EXIT:
            begin
                cmd.step       = 1'b1;
                cmd.exit_apply = stat.walk_done;
                if (stat.walk_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // hold until the output register can take the transaction
                cmd.load_out = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/lld_datapath.sv
// Datapath for the least-loaded dispatcher: worker load memory, worker count,
// scan/compaction pointer, best-candidate tracker and output register.
// Depends on lld_pkg; driven by lld_ctrl commands.
`timescale 1ns / 1ps

module lld_datapath #(
    parameter int MAX_WORKERS = lld_pkg::MAX_WORKERS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lld_pkg::lld_cmd_t                 cmd,
    output lld_pkg::lld_stat_t                stat,
    input  logic [lld_pkg::FUNC_W-1:0]        in_func,
    input  logic [lld_pkg::INDEX_W-1:0]       in_index,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lld_pkg::COOKS_W-1:0]       cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lld_pkg::INDEX_W-1:0]       out_assigned,
    output logic                              out_new,
    output logic [lld_pkg::STAT_W-1:0]        out_status,
    output logic [lld_pkg::COUNT_W-1:0]       out_count
);
    import lld_pkg::*;

    localparam int IW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CW = $clog2(MAX_WORKERS + 1);
    localparam int XW = CW + INDEX_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WORKERS);

    logic [LOAD_W-1:0] mem [MAX_WORKERS];

    logic [COOKS_W-1:0] cooks_reg;
    logic [FUNC_W-1:0]  func_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      ptr_reg;
    logic               pend_reg;
    logic [IW-1:0]      pend_ptr_reg;
    logic               found_reg;
    logic [IW-1:0]      best_reg;
    logic [LOAD_W-1:0]  best_load_reg;
    logic [LOAD_W-1:0]  rd_data_reg;
    logic [INDEX_W-1:0] res_assigned_reg;
    logic               res_fresh_reg;
    logic [STAT_W-1:0]  res_status_reg;
    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_assigned_reg;
    logic               out_new_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic [XW-1:0]      idx_ext;
    logic [XW-1:0]      count_ext;
    logic [XW-1:0]      best_ext;
    logic [XW-1:0]      ptr_plus;
    logic               idx_active;
    logic [LOAD_W-1:0]  cap;
    logic               issue;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [LOAD_W-1:0]  wr_data;
    logic               better;
    logic               is_dispatch;

    assign idx_ext     = {{CW{1'b0}}, idx_reg};
    assign count_ext   = {{INDEX_W{1'b0}}, count_reg};
    assign best_ext    = {{(XW-IW){1'b0}}, best_reg};
    assign ptr_plus    = idx_ext + XW'(1);
    assign idx_active  = idx_ext < count_ext;
    assign cap         = {cooks_reg, 1'b0};
    assign is_dispatch = (func_reg == FUNC_DISPATCH);
    assign issue       = cmd.step && (ptr_reg < count_reg);
    assign rd_addr     = cmd.done_rd ? idx_ext[IW-1:0] : ptr_reg[IW-1:0];
    assign better      = (rd_data_reg < cap) && (!found_reg || rd_data_reg < best_load_reg);

    assign cfg_ready = 1'b1;

    assign stat.func       = func_reg;
    assign stat.idx_active = idx_active;
    assign stat.walk_done  = (ptr_reg >= count_reg) && !pend_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    // one write port: load update, append, or shift-down during exit
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = best_reg;
        wr_data = best_load_reg + LOAD_W'(1);
        if (cmd.disp_apply)
        begin
            if (found_reg)
            begin
                wr_en = 1'b1;
            end
            else if (count_reg < MAX_CNT)
            begin
                wr_en   = 1'b1;
                wr_addr = count_reg[IW-1:0];
                wr_data = LOAD_W'(1);
            end
        end
        else if (cmd.done_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_ext[IW-1:0];
            wr_data = (rd_data_reg != '0) ? rd_data_reg - LOAD_W'(1) : rd_data_reg;
        end
        else if (cmd.step && !is_dispatch && pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_ptr_reg - IW'(1);
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // item, tracker and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg <= in_func;
            idx_reg  <= in_index;
        end
        if (cmd.step && is_dispatch && pend_reg && better)
        begin
            best_reg      <= pend_ptr_reg;
            best_load_reg <= rd_data_reg;
        end
        if (issue)
        begin
            pend_ptr_reg <= ptr_reg[IW-1:0];
        end
        if (cmd.decode)
        begin
            res_assigned_reg <= idx_reg;
            res_fresh_reg    <= 1'b0;
            res_status_reg   <= ((func_reg == FUNC_DONE || func_reg == FUNC_EXIT) && !idx_active)
                                ? STAT_INACTIVE : STAT_OK;
        end
        if (cmd.disp_apply)
        begin
            if (found_reg)
            begin
                res_assigned_reg <= best_ext[INDEX_W-1:0];
            end
            else if (count_reg < MAX_CNT)
            begin
                res_assigned_reg <= count_ext[INDEX_W-1:0];
                res_fresh_reg    <= 1'b1;
            end
            else
            begin
                res_status_reg <= STAT_FULL;
            end
        end
        if (cmd.load_out)
        begin
            out_assigned_reg <= res_assigned_reg;
            out_new_reg      <= res_fresh_reg;
            out_status_reg   <= res_status_reg;
            out_count_reg    <= count_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooks_reg     <= COOKS_RESET;
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cooks_reg <= cfg_data;
            end
            if (cmd.scan_start)
            begin
                ptr_reg   <= '0;
                pend_reg  <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (cmd.exit_start)
            begin
                ptr_reg  <= ptr_plus[CW-1:0];
                pend_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    ptr_reg <= ptr_reg + CW'(1);
                end
                if (is_dispatch && pend_reg && better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.disp_apply && !found_reg && count_reg < MAX_CNT)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.exit_apply)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_assigned = out_assigned_reg;
    assign out_new      = out_new_reg;
    assign out_status   = out_status_reg;
    assign out_count    = out_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("worker count above table size");

    a_best_qualifies: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.disp_apply && found_reg) |-> (best_load_reg < cap))
        else $error("chosen worker is at or above capacity");

    a_exit_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exit_apply |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("exit did not remove exactly one worker");

    a_out_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.load_out)
        else $error("result overwritten before transaction");
`endif

endmodule

// File: rtl/least_loaded_dispatcher_unit.sv
// Top level of the least-loaded dispatcher: stream ports, configuration
// port, controller and datapath. Depends on lld_pkg, lld_ctrl, lld_datapath.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: worker_index; tuser: func
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: result fields
//  cfg       in         cfg_valid / cfg_ready          cfg_data: cooks_per_worker
//
// One transaction at a time, from the accept cycle through the cycle that loads the
// output register. Dispatch scans the load memory one entry a cycle through its
// registered read port. Done reads the entry and writes it back decremented; exit
// shifts each entry above worker_index down by one place. Reset clears the worker
// count; load entries are written before read. A stalled output holds the
// controller in its result state.
`timescale 1ns / 1ps

module least_loaded_dispatcher_unit #(
    parameter int MAX_WORKERS = lld_pkg::MAX_WORKERS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [3:0] worker_index, [7:4] zero
    input  logic [lld_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] func
    input  logic [lld_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [3:0] assigned_index, [4] new_worker, [6:5] status, [11:7] active_count,
    // [15:12] zero
    output logic [lld_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lld_pkg::COOKS_W-1:0]       cfg_data
);
    import lld_pkg::*;

    lld_cmd_t  cmd;
    lld_stat_t stat;

    logic [INDEX_W-1:0] out_assigned;
    logic               out_new;
    logic [STAT_W-1:0]  out_status;
    logic [COUNT_W-1:0] out_count;

    lld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lld_datapath #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_func      (s_axis_tuser[FUNC_W-1:0]),
        .in_index     (s_axis_tdata[INDEX_W-1:0]),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_assigned (out_assigned),
        .out_new      (out_new),
        .out_status   (out_status),
        .out_count    (out_count)
    );

    assign m_axis_tdata = {4'b0000, out_count, out_status, out_new, out_assigned};

endmodule
